[rtl/lfu_cache_table_top_defines.svh]
// ----------------------------------------------------------------------------
// lfu cache table assertion macros
// concurrent assertion forms used by the checker file of the cache table
// ----------------------------------------------------------------------------
`ifndef LFU_CACHE_TABLE_TOP_DEFINES_SVH
`define LFU_CACHE_TABLE_TOP_DEFINES_SVH

// consequent must hold in the cycle after the antecedent
`define LFUCT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define LFUCT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

[rtl/lfuct_pkg.sv]
// ----------------------------------------------------------------------------
// lfu cache table package
// sizes, transfer payload types, scan types and state codes of the cache table
// ----------------------------------------------------------------------------
`default_nettype none

package lfuct_pkg;

   // table geometry
   localparam int ENTRIES    = 16;
   localparam int KEY_BITS   = 32;
   localparam int COUNT_BITS = 32;
   localparam int DATA_BITS  = 32;
   localparam int CAP_BITS   = 5;
   localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OCC_BITS   = $clog2(ENTRIES + 1);

   localparam logic [CAP_BITS-1:0]   CAP_RESET = CAP_BITS'(16);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [IDX_BITS-1:0]   IDX_LAST  = IDX_BITS'(ENTRIES - 1);

   // request kinds
   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_PUT = 1'b1;

   typedef struct packed {
      logic                        func;
      logic [31:0]                 lookup_key;
      logic signed [DATA_BITS-1:0] store_value;
   } req_type;

   typedef struct packed {
      logic                        found;
      logic signed [DATA_BITS-1:0] read_value;
   } rsp_type;

   // one entry as seen by the scan unit
   typedef struct packed {
      logic                  valid;
      logic [KEY_BITS-1:0]   key;
      logic [DATA_BITS-1:0]  value;
      logic [COUNT_BITS-1:0] count;
      logic [IDX_BITS-1:0]   rank;
   } entry_view_type;

   // what one pass over the table found
   typedef struct packed {
      logic                  hit;
      logic [IDX_BITS-1:0]   hit_idx;
      logic [DATA_BITS-1:0]  hit_value;
      logic [COUNT_BITS-1:0] hit_count;
      logic [IDX_BITS-1:0]   hit_rank;
      logic                  vic_found;
      logic [IDX_BITS-1:0]   vic_idx;
      logic [COUNT_BITS-1:0] vic_count;
      logic [IDX_BITS-1:0]   vic_rank;
      logic                  free_found;
      logic [IDX_BITS-1:0]   free_idx;
   } scan_result_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_HOLD
   } state_type;

endpackage

`default_nettype wire

[rtl/lfuct_scan.sv]
// ----------------------------------------------------------------------------
// lfu cache table scan unit
// visits one entry a cycle while step is high: key match, first free slot and the replacement
// victim (lowest use count, then least recent) through one shared compare
// ----------------------------------------------------------------------------
`default_nettype none

module lfuct_scan (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                step,
   input  logic [lfuct_pkg::IDX_BITS-1:0]      idx,
   input  lfuct_pkg::entry_view_type           entry,
   input  logic [lfuct_pkg::KEY_BITS-1:0]      key,
   output lfuct_pkg::scan_result_type          result
);
   import lfuct_pkg::*;

   scan_result_type res_ff;
   scan_result_type res_in;
   logic            better;

   // shared compare: lower count wins, equal counts go to the older entry
   assign better = (entry.count < res_ff.vic_count) ||
                   ((entry.count == res_ff.vic_count) && (entry.rank < res_ff.vic_rank));

   // accumulate over the pass
   always_comb begin
      res_in = res_ff;
      if (start) begin
         res_in.hit        = 1'b0;
         res_in.vic_found  = 1'b0;
         res_in.free_found = 1'b0;
      end else if (step) begin
         if (entry.valid && (entry.key == key) && !res_ff.hit) begin
            res_in.hit       = 1'b1;
            res_in.hit_idx   = idx;
            res_in.hit_value = entry.value;
            res_in.hit_count = entry.count;
            res_in.hit_rank  = entry.rank;
         end
         if (entry.valid && (!res_ff.vic_found || better)) begin
            res_in.vic_found = 1'b1;
            res_in.vic_idx   = idx;
            res_in.vic_count = entry.count;
            res_in.vic_rank  = entry.rank;
         end
         if (!entry.valid && !res_ff.free_found) begin
            res_in.free_found = 1'b1;
            res_in.free_idx   = idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= '0;
      end else begin
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule

`default_nettype wire

[rtl/lfu_cache_table_top.sv]
// ----------------------------------------------------------------------------
// lfu cache table
// key-value store with least-frequently-used replacement, least recent first
// among equal use counts; one get or put per request, one response each
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | req_data (func, key, value)
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_data (found, read value)
//  csr     | in        | csr_valid/csr_ready  | csr_data (capacity limit)
//
//  a request passes the accept state, a scan of every table entry through
//  the scan unit's single compare, and the update state
//  the response register is loaded at the update when its slot is free; a stalled response keeps
//  the finished result in a holding register and new requests wait on it
//  reset clears the valid bits, occupancy and handshakes at once; capacity
//  returns to 16; csr writes are always taken
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_cache_table_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  lfuct_pkg::req_type                req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output lfuct_pkg::rsp_type                rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lfuct_pkg::CAP_BITS-1:0]    csr_data
);
   import lfuct_pkg::*;

   // control state
   state_type               state_ff, state_in;
   logic [IDX_BITS-1:0]     idx_ff, idx_in;
   logic [CAP_BITS-1:0]     cap_ff;
   logic [OCC_BITS-1:0]     occ_ff, occ_in;
   logic                    valid_ff [ENTRIES];
   logic                    valid_in [ENTRIES];
   logic                    rsp_valid_ff;

   // payload state
   req_type                 req_ff;
   rsp_type                 rsp_ff;
   rsp_type                 hold_ff;
   logic [KEY_BITS-1:0]     key_ff   [ENTRIES];
   logic [DATA_BITS-1:0]    value_ff [ENTRIES];
   logic [COUNT_BITS-1:0]   count_ff [ENTRIES];
   logic [IDX_BITS-1:0]     rank_ff  [ENTRIES];
   logic [IDX_BITS-1:0]     rank_in  [ENTRIES];

   // sequencer outputs
   logic                    start, step, update, load_now, load_hold, slot_free;

   // scan interface
   entry_view_type          entry;
   scan_result_type         sr;

   // update decisions
   logic                    is_put, cap_zero, full;
   logic                    do_touch, do_install, do_evict;
   logic [IDX_BITS-1:0]     install_idx;
   logic [OCC_BITS-1:0]     occ_after_evict;
   logic [COUNT_BITS-1:0]   count_up;
   rsp_type                 result;

   assign csr_ready = 1'b1;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   // sequencer next state
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      req_ready = 1'b0;
      start     = 1'b0;
      step      = 1'b0;
      update    = 1'b0;
      load_now  = 1'b0;
      load_hold = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               start    = 1'b1;
               idx_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            step   = 1'b1;
            idx_in = IDX_BITS'(idx_ff + 1'b1);
            if (idx_ff == IDX_LAST) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            update = 1'b1;
            if (slot_free) begin
               load_now = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (slot_free) begin
               load_hold = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // request capture
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
   end

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         cap_ff <= csr_data;
      end
   end

   // entry at the scan position
   always_comb begin
      entry.valid = valid_ff[idx_ff];
      entry.key   = key_ff[idx_ff];
      entry.value = value_ff[idx_ff];
      entry.count = count_ff[idx_ff];
      entry.rank  = rank_ff[idx_ff];
   end

   lfuct_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .step   (step),
      .idx    (idx_ff),
      .entry  (entry),
      .key    (req_ff.lookup_key[KEY_BITS-1:0]),
      .result (sr)
   );

   // update decisions from the finished scan
   always_comb begin
      is_put   = (req_ff.func == FUNC_PUT);
      cap_zero = (cap_ff == '0);
      if (32'(cap_ff) >= ENTRIES) begin
         full = (32'(occ_ff) >= ENTRIES);
      end else begin
         full = (32'(occ_ff) >= 32'(cap_ff));
      end
      do_touch   = sr.hit && (!is_put || !cap_zero);
      do_install = is_put && !cap_zero && !sr.hit;
      do_evict   = do_install && full && sr.vic_found;
      if (do_evict) begin
         install_idx = (sr.free_found && (sr.free_idx < sr.vic_idx)) ? sr.free_idx
                                                                     : sr.vic_idx;
      end else begin
         install_idx = sr.free_idx;
      end
      occ_after_evict = do_evict ? OCC_BITS'(occ_ff - 1'b1) : occ_ff;
      count_up = (sr.hit_count == COUNT_MAX) ? sr.hit_count
                                             : COUNT_BITS'(sr.hit_count + 1'b1);
      result.found      = sr.hit;
      result.read_value = (!is_put && sr.hit) ? sr.hit_value : '1;
   end

   // per-entry recency and valid lanes
   always_comb begin
      for (int j = 0; j < ENTRIES; j++) begin
         rank_in[j]  = rank_ff[j];
         valid_in[j] = valid_ff[j];
         if (valid_ff[j]) begin
            if (do_touch) begin
               if (IDX_BITS'(j) == sr.hit_idx) begin
                  rank_in[j] = IDX_BITS'(occ_ff - 1'b1);
               end else if (rank_ff[j] > sr.hit_rank) begin
                  rank_in[j] = IDX_BITS'(rank_ff[j] - 1'b1);
               end
            end
            if (do_evict) begin
               if (IDX_BITS'(j) == sr.vic_idx) begin
                  valid_in[j] = 1'b0;
               end else if (rank_ff[j] > sr.vic_rank) begin
                  rank_in[j] = IDX_BITS'(rank_ff[j] - 1'b1);
               end
            end
         end
         if ((do_evict || sr.free_found) && do_install && (IDX_BITS'(j) == install_idx)) begin
            valid_in[j] = 1'b1;
            rank_in[j]  = IDX_BITS'(occ_after_evict);
         end
      end
      occ_in = occ_ff;
      if ((do_evict || sr.free_found) && do_install) begin
         occ_in = OCC_BITS'(occ_after_evict + 1'b1);
      end
   end

   // valid bits and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
         for (int j = 0; j < ENTRIES; j++) begin
            valid_ff[j] <= 1'b0;
         end
      end else if (update) begin
         occ_ff <= occ_in;
         for (int j = 0; j < ENTRIES; j++) begin
            valid_ff[j] <= valid_in[j];
         end
      end
   end

   // entry payload writes
   always_ff @(posedge clock) begin
      if (update) begin
         for (int j = 0; j < ENTRIES; j++) begin
            rank_ff[j] <= rank_in[j];
         end
         if (do_touch) begin
            count_ff[sr.hit_idx] <= count_up;
            if (is_put) begin
               value_ff[sr.hit_idx] <= req_ff.store_value;
            end
         end else if (do_install && (do_evict || sr.free_found)) begin
            key_ff[install_idx]   <= req_ff.lookup_key[KEY_BITS-1:0];
            value_ff[install_idx] <= req_ff.store_value;
            count_ff[install_idx] <= COUNT_BITS'(1);
         end
      end
   end

   // response register and holding register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_now || load_hold) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_now) begin
         rsp_ff <= result;
      end else if (load_hold) begin
         rsp_ff <= hold_ff;
      end
      if (update && !load_now) begin
         hold_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

[rtl/lfuct_checker.sv]
// ----------------------------------------------------------------------------
// lfu cache table port checker
// watches the top level ports for sequencing and response rules
// ----------------------------------------------------------------------------
`default_nettype none

`include "lfu_cache_table_top_defines.svh"

module lfuct_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input lfuct_pkg::rsp_type                rsp_data,
   input logic                              csr_valid,
   input logic                              csr_ready
);
   import lfuct_pkg::*;

   logic req_xfer;
   logic miss_shown;

   assign req_xfer   = req_valid && req_ready;
   assign miss_shown = rsp_valid && !rsp_data.found;

   // block is busy right after taking a request
   `LFUCT_ASSERT_NEXT(a_busy_after_req, clock, reset, req_xfer, !req_ready, "ready after request transfer")

   // no response can appear the cycle after a request is taken while none is offered
   `LFUCT_ASSERT_NEXT(a_no_early_rsp, clock, reset, req_xfer && !rsp_valid, !rsp_valid, "response too early")

   // a miss always reads minus one
   `LFUCT_ASSERT_NOW(a_miss_value, clock, reset, miss_shown, rsp_data.read_value == '1, "miss value not minus one")

   // a stalled response stays offered
   `LFUCT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled response dropped or changed")

   // configuration port never stalls
   `LFUCT_ASSERT_NOW(a_csr_ready, clock, reset, csr_valid, csr_ready, "configuration write stalled")

endmodule

bind lfu_cache_table_top lfuct_checker u_lfuct_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready)
);

`default_nettype wire
